// File: design/tsw_pkg.sv
package tsw_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // geometry register width and derived counter widths
   localparam int DIM_W    = 11;
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int ROW_W    = DIM_W;
   localparam int OUT_W    = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int AREA_W   = 2 * DIM_W;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_SUBPASS = CSR_IDX_W'(2);

   // neighbor count limits for removal
   localparam logic [3:0] MIN_NEIGHBORS = 4'd2;
   localparam logic [3:0] MAX_NEIGHBORS = 4'd6;
   localparam logic [3:0] RING_CHANGES  = 4'd2;

   // line store word: bit 0 upper row, bit 1 middle row
   typedef logic [1:0] line_word_type;

   // one pixel on its way from the scan counters to the window stage
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             pix;
      logic             emit;
      logic             last;
      logic             top;
      logic             bot;
      logic             lft;
      logic             rgt;
      logic             fwd;
      line_word_type    fwd_word;
   } scan_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [3:0] count8(input logic [7:0] v);
      logic [3:0] n;
      n = '0;
      for (int k = 0; k < 8; k++) begin
         n = n + 4'(v[k]);
      end
      return n;
   endfunction

endpackage

// File: design/tsw_line_store.sv
module tsw_line_store (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [tsw_pkg::COL_W-1:0]   rd_addr,
   output tsw_pkg::line_word_type      rd_data,
   input  logic                        wr_en,
   input  logic [tsw_pkg::COL_W-1:0]   wr_addr,
   input  tsw_pkg::line_word_type      wr_data
);
   import tsw_pkg::*;

   line_word_type mem [MAX_WIDTH];
   line_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/tsw_scan.sv
module tsw_scan (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic                         pixel_in,
   input  logic                         drain,
   input  logic [tsw_pkg::DIM_W-1:0]    width_cfg,
   input  logic [tsw_pkg::DIM_W-1:0]    height_cfg,
   input  logic                         s1_adv,
   input  tsw_pkg::line_word_type       wr_word,
   output logic                         s1_valid,
   output tsw_pkg::scan_type            s1,
   output logic                         rd_en,
   output logic [tsw_pkg::COL_W-1:0]    rd_addr
);
   import tsw_pkg::*;

   logic [COL_W-1:0]  col_ff,  col_in;
   logic [ROW_W-1:0]  row_ff,  row_in;
   logic [OUT_W-1:0]  cnt_ff,  cnt_in;
   logic              s1_valid_ff;
   scan_type          s1_ff, s1_in;

   logic [DIM_W-1:0]  w, h;
   logic [AREA_W-1:0] area;
   logic              flushing, drop, take, pix;
   logic [COL_W-1:0]  x;
   logic [DIM_W-1:0]  x_next, c;
   logic [ROW_W-1:0]  r;
   logic              wrap, emit, last;

   always_comb begin
      w = clamp_dim(width_cfg, DIM_W'(MAX_WIDTH));
      h = clamp_dim(height_cfg, DIM_W'(MAX_HEIGHT));
      area = AREA_W'(w) * AREA_W'(h);

      flushing = row_ff >= ROW_W'(h);
      drop = !flushing && drain;
      req_tready = !s1_valid_ff || s1_adv;
      take = req_tvalid && req_tready && !drop;
      pix = flushing ? 1'b0 : pixel_in;

      // a column count left beyond a narrowed width restarts at zero
      x = (DIM_W'(col_ff) >= w) ? '0 : col_ff;
      emit = (row_ff >= ROW_W'(2)) || (row_ff == ROW_W'(1) && x != '0);
      if (x == '0) begin
         r = row_ff - ROW_W'(2);
         c = w - DIM_W'(1);
      end else begin
         r = row_ff - ROW_W'(1);
         c = DIM_W'(x) - DIM_W'(1);
      end
      last = emit && (AREA_W'(cnt_ff) + AREA_W'(1) >= area);

      x_next = DIM_W'(x) + DIM_W'(1);
      wrap = x_next >= w;

      col_in = col_ff;
      row_in = row_ff;
      cnt_in = cnt_ff;
      if (take) begin
         if (last) begin
            col_in = '0;
            row_in = '0;
            cnt_in = '0;
         end else begin
            col_in = wrap ? '0 : x_next[COL_W-1:0];
            row_in = wrap ? row_ff + ROW_W'(1) : row_ff;
            cnt_in = emit ? cnt_ff + OUT_W'(1) : cnt_ff;
         end
      end

      s1_in.col  = x;
      s1_in.pix  = pix;
      s1_in.emit = emit;
      s1_in.last = last;
      s1_in.top  = r != '0;
      s1_in.bot  = ({1'b0, r} + (ROW_W+1)'(1)) < (ROW_W+1)'(h);
      s1_in.lft  = c != '0;
      s1_in.rgt  = ({1'b0, c} + (DIM_W+1)'(1)) < {1'b0, w};
      // the item ahead writes this column at the same edge as our read
      s1_in.fwd  = s1_valid_ff && s1_adv && (s1_ff.col == x);
      s1_in.fwd_word = wr_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         cnt_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         cnt_ff <= cnt_in;
         if (take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
      end
      if (take) begin
         s1_ff <= s1_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1       = s1_ff;
   assign rd_en    = take;
   assign rd_addr  = x;

endmodule

// File: design/tsw_eval.sv
module tsw_eval (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         s1_valid,
   input  tsw_pkg::scan_type            s1,
   input  tsw_pkg::line_word_type       rd_data,
   input  logic                         subpass,
   output logic                         s1_adv,
   output logic                         wr_en,
   output logic [tsw_pkg::COL_W-1:0]    wr_addr,
   output tsw_pkg::line_word_type       wr_word,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic                         pixel_out,
   output logic                         removed,
   output logic                         frame_last,
   output logic                         any_removed
);
   import tsw_pkg::*;

   logic [8:0]    win_ff, win_in;
   logic          seen_ff;
   logic          rsp_valid_ff;
   logic          pix_out_ff, rem_ff, last_ff, any_ff;

   line_word_type lines;
   logic [7:0]    nb, ring;
   logic [3:0]    cnt, trans;
   logic          p, dir, rem;

   always_comb begin
      s1_adv = s1_valid && (!s1.emit || !rsp_valid_ff || rsp_tready);
      lines = s1.fwd ? s1.fwd_word : rd_data;
      // window bit = column*3 + row, column 0 oldest, row 0 top
      win_in = {s1.pix, lines[1], lines[0], win_ff[8:3]};
      wr_word = {s1.pix, lines[1]};

      p = win_in[4];
      nb[0] = s1.top & win_in[3];
      nb[1] = s1.top & s1.rgt & win_in[6];
      nb[2] = s1.rgt & win_in[7];
      nb[3] = s1.bot & s1.rgt & win_in[8];
      nb[4] = s1.bot & win_in[5];
      nb[5] = s1.bot & s1.lft & win_in[2];
      nb[6] = s1.lft & win_in[1];
      nb[7] = s1.top & s1.lft & win_in[0];
      ring = nb ^ {nb[0], nb[7:1]};
      cnt = count8(nb);
      trans = count8(ring);
      if (subpass) begin
         dir = !nb[2] || !nb[4] || (!nb[0] && !nb[6]);
      end else begin
         dir = !nb[0] || !nb[6] || (!nb[2] && !nb[4]);
      end
      rem = p && cnt >= MIN_NEIGHBORS && cnt <= MAX_NEIGHBORS
            && trans == RING_CHANGES && dir;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) begin
            win_ff <= (s1.emit && s1.last) ? '0 : win_in;
         end
         if (s1_adv && s1.emit) begin
            seen_ff      <= s1.last ? 1'b0 : (seen_ff | rem);
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (s1_adv && s1.emit) begin
         pix_out_ff <= p && !rem;
         rem_ff     <= rem;
         last_ff    <= s1.last;
         any_ff     <= s1.last && (seen_ff || rem);
      end
   end

   assign wr_en       = s1_adv;
   assign wr_addr     = s1.col;
   assign rsp_tvalid  = rsp_valid_ff;
   assign pixel_out   = pix_out_ff;
   assign removed     = rem_ff;
   assign frame_last  = last_ff;
   assign any_removed = any_ff;

endmodule

// File: design/thinning_subpass_window_top.sv
// latency: a pixel's result is delayed by image_width+1 items; an item passes the scan
//    stage register and then the output register, and either can stall on back-pressure
// throughput: one item per cycle while rsp_tready holds, set by the line store doing one read
//    and one write per cycle next to a combinational window test
// reset: synchronous, active high; clears counters, window, the removal-seen flag and
//    the valid flags, geometry to 1024 x 1024 and subpass to 0; line stores are not cleared
module thinning_subpass_window_top (
   input  logic                          clock,
   input  logic                          reset,
   // pixel input
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [0] pixel_in, [7:1] zero
   input  logic                          req_tuser,   // [0] drain
   // result output
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // [0] pixel_out, [1] removed,
                                                      // [2] any_removed, [7:3] zero
   output logic                          rsp_tlast,   // frame_last
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tsw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tsw_pkg::DIM_W-1:0]     csr_data
);
   import tsw_pkg::*;

   // geometry and subpass registers, raw as written
   logic [DIM_W-1:0] width_ff;
   logic [DIM_W-1:0] height_ff;
   logic             subpass_ff;

   // scan stage to window stage
   logic             s1_valid;
   scan_type         s1;
   logic             s1_adv;

   // line store ports
   logic             rd_en;
   logic [COL_W-1:0] rd_addr;
   line_word_type    rd_data;
   logic             wr_en;
   logic [COL_W-1:0] wr_addr;
   line_word_type    wr_word;

   // result fields
   logic             pixel_out;
   logic             removed;
   logic             any_removed;

   // register writes are never stalled
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= DIM_RESET;
         height_ff  <= DIM_RESET;
         subpass_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_WIDTH:   width_ff   <= csr_data;
            REG_HEIGHT:  height_ff  <= csr_data;
            REG_SUBPASS: subpass_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // raster counters, edge masks and line store read address
   tsw_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .pixel_in   (req_tdata[0]),
      .drain      (req_tuser),
      .width_cfg  (width_ff),
      .height_cfg (height_ff),
      .s1_adv     (s1_adv),
      .wr_word    (wr_word),
      .s1_valid   (s1_valid),
      .s1         (s1),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr)
   );

   // two previous rows, one 2-bit word per column
   tsw_line_store u_lines (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word)
   );

   // 3x3 window, removal test and output register
   tsw_eval u_eval (
      .clock       (clock),
      .reset       (reset),
      .s1_valid    (s1_valid),
      .s1          (s1),
      .rd_data     (rd_data),
      .subpass     (subpass_ff),
      .s1_adv      (s1_adv),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_word     (wr_word),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .pixel_out   (pixel_out),
      .removed     (removed),
      .frame_last  (rsp_tlast),
      .any_removed (any_removed)
   );

   assign rsp_tdata = {5'b0, any_removed, removed, pixel_out};

endmodule

// File: design/tsw_checker.sv
module tsw_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // frame-wide flag only on the closing pixel
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tlast)
      else $error("any_removed outside frame end");

   // a removed pixel leaves as background
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> !rsp_tdata[0])
      else $error("removed pixel still set");

   // a removal on the closing pixel must show in the frame flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && rsp_tdata[1] |-> rsp_tdata[2])
      else $error("frame flag missed a removal");

   // nothing offered right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind thinning_subpass_window_top tsw_checker u_tsw_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// File: tb/thinning_subpass_window_top_tb.sv
module thinning_subpass_window_top_tb;
   import tsw_pkg::*;

   // run length and pacing
   localparam int unsigned CYCLE_LIMIT  = 2_000_000;
   localparam int unsigned RANDOM_ITEMS = 900;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned SETTLE       = 8;
   localparam int unsigned MAX_REPORTS  = 40;

   // index with no register behind it, writes to it are dropped
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = CSR_IDX_W'(3);

   // one input transfer: pixel value and drain flag
   typedef struct packed {
      bit pix;
      bit drain;
   } pixel_item_type;

   // one result transfer as the thinning pass should produce it
   typedef struct packed {
      bit pix_out;
      bit removed;
      bit frame_last;
      bit any_removed;
   } pixel_result_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = '0;
   logic                 req_tuser  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [DIM_W-1:0]     csr_data   = '0;

   thinning_subpass_window_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // predictor state: our own copy of registers, line stores and scan
   // ---------------------------------------------------------------
   bit [DIM_W-1:0] geom_width_reg  = DIM_RESET;
   bit [DIM_W-1:0] geom_height_reg = DIM_RESET;
   bit             subpass_reg     = 1'b0;
   bit             up_line  [MAX_WIDTH];
   bit             mid_line [MAX_WIDTH];
   bit [8:0]       win;          // bit = column*3 + row, column 0 left, row 0 top
   bit [9:0]       col_pos;
   bit [10:0]      row_pos;
   bit [19:0]      out_pos;
   bit             removal_seen;

   pixel_item_type    pixels_to_send[$];
   pixel_result_type  thinned_pixels_due[$];

   // bookkeeping
   int unsigned items_pushed    = 0;
   int unsigned req_xfers       = 0;
   int unsigned results_checked = 0;
   int unsigned frames_done     = 0;
   int unsigned drains_dropped  = 0;
   int unsigned reg_writes      = 0;
   int unsigned pixels_removed  = 0;
   int unsigned errors          = 0;
   int unsigned cycles          = 0;

   // handshake and pacing state of the clocked processes; req_took and rsp_hold are shared
   bit req_took  = 1'b0;
   bit rsp_hold  = 1'b0;
   bit req_calm  = 1'b0;
   bit rdy_calm  = 1'b0;
   int unsigned req_gap = 0;
   int unsigned rdy_gap = 0;
   event hold_kick;

   // geometry as the block uses it: zero counts as one, large values saturate
   function automatic int unsigned eff_dim(input bit [DIM_W-1:0] v, input int unsigned cap);
      if (v == 0) return 1;
      if (v > cap) return cap;
      return v;
   endfunction

   // idle length: mostly short, now and then a long one
   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 1;
      if (r < 88) return $urandom_range(2, 4);
      if (r < 97) return $urandom_range(5, 12);
      return $urandom_range(20, 40);
   endfunction

   task automatic note_mismatch(input string what);
      if (errors < MAX_REPORTS) begin
         $display("mismatch at cycle %0d: %s", cycles, what);
      end
      errors++;
   endtask

   task automatic check_bit(input string field, input logic got, input bit want);
      if (got !== want) begin
         note_mismatch($sformatf("%s got %b want %b (result %0d)", field, got, want,
                                 results_checked));
      end
   endtask

   // one accepted input item through the thinning sub-pass; queues the
   // result it releases, if any
   task automatic predict_thinned_pixel(input bit pix_in, input bit drain_in);
      int unsigned      w, h, x, r, c, nxt, cnt, changes;
      bit               flushing, pix, emit, top, bot, lft, rgt, dir_ok, rem, last;
      bit [2:0]         colbits;
      bit [7:0]         ring;          // N, NE, E, SE, S, SW, W, NW
      pixel_result_type res;
      w = eff_dim(geom_width_reg, MAX_WIDTH);
      h = eff_dim(geom_height_reg, MAX_HEIGHT);
      flushing = row_pos >= h;
      // drain before the whole frame is in: dropped without a trace
      if (!flushing && drain_in) begin
         drains_dropped++;
         return;
      end
      pix = flushing ? 1'b0 : pix_in;
      if (col_pos >= w) col_pos = '0;
      x = col_pos;
      colbits = {pix, mid_line[x], up_line[x]};
      win = {colbits, win[8:3]};
      up_line[x] = mid_line[x];
      mid_line[x] = pix;
      emit = row_pos >= 2 || (row_pos == 1 && x >= 1);
      if (x == 0) begin
         r = row_pos - 2;
         c = w - 1;
      end else begin
         r = row_pos - 1;
         c = x - 1;
      end
      nxt = x + 1;
      if (nxt >= w) begin
         col_pos = '0;
         row_pos++;
      end else begin
         col_pos = COL_W'(nxt);
      end
      if (!emit) return;

      // neighbors outside the image read as zero
      top = r > 0;
      bot = r + 1 < h;
      lft = c > 0;
      rgt = c + 1 < w;
      ring[0] = top & win[3];
      ring[1] = top & rgt & win[6];
      ring[2] = rgt & win[7];
      ring[3] = bot & rgt & win[8];
      ring[4] = bot & win[5];
      ring[5] = bot & lft & win[2];
      ring[6] = lft & win[1];
      ring[7] = top & lft & win[0];
      cnt = 0;
      changes = 0;
      for (int k = 0; k < 8; k++) begin
         cnt += ring[k];
         changes += ring[k] ^ ring[(k + 1) % 8];
      end
      if (subpass_reg) dir_ok = !ring[2] || !ring[4] || (!ring[0] && !ring[6]);
      else             dir_ok = !ring[0] || !ring[6] || (!ring[2] && !ring[4]);
      rem = win[4] && cnt >= MIN_NEIGHBORS && cnt <= MAX_NEIGHBORS &&
            changes == RING_CHANGES && dir_ok;
      last = out_pos + 1 >= w * h;

      res.pix_out     = win[4] && !rem;
      res.removed     = rem;
      res.frame_last  = last;
      res.any_removed = last && (removal_seen || rem);
      thinned_pixels_due.push_back(res);

      if (rem) begin
         removal_seen = 1'b1;
         pixels_removed++;
      end
      if (last) begin
         win = '0;
         col_pos = '0;
         row_pos = '0;
         out_pos = '0;
         removal_seen = 1'b0;
         frames_done++;
      end else begin
         out_pos++;
      end
   endtask

   // ---------------------------------------------------------------
   // monitor: everything sampled at the rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin : observer
      pixel_result_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("thinning_subpass_window_top verification failed");
         $finish;
      end else begin
         req_took = 1'b0;
         if (!reset) begin
            // register write transfer updates our copy at the same edge
            if (csr_valid && csr_ready) begin
               reg_writes++;
               case (csr_index)
                  REG_WIDTH:   geom_width_reg  = csr_data;
                  REG_HEIGHT:  geom_height_reg = csr_data;
                  REG_SUBPASS: subpass_reg     = csr_data[0];
                  default: ;
               endcase
            end
            // result transfer against the oldest outstanding pixel
            if (rsp_tvalid && rsp_tready) begin
               if (thinned_pixels_due.size() == 0) begin
                  note_mismatch($sformatf("result with nothing outstanding, tdata %h tlast %b",
                                          rsp_tdata, rsp_tlast));
               end else begin
                  want = thinned_pixels_due.pop_front();
                  check_bit("pixel_out", rsp_tdata[0], want.pix_out);
                  check_bit("removed", rsp_tdata[1], want.removed);
                  check_bit("any_removed", rsp_tdata[2], want.any_removed);
                  check_bit("frame_last", rsp_tlast, want.frame_last);
                  if (rsp_tdata[7:3] !== 5'b0) begin
                     note_mismatch($sformatf("tdata padding %b not zero", rsp_tdata[7:3]));
                  end
               end
               results_checked++;
            end
            // input transfer goes through the predictor
            if (req_tvalid && req_tready) begin
               req_took = 1'b1;
               req_xfers++;
               predict_thinned_pixel(req_tdata[0], req_tuser);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // pixel driver: pops the pending queue at the falling edge
   // ---------------------------------------------------------------
   always @(negedge clock) begin : pixel_driver
      pixel_item_type it;
      logic           nv;
      logic [7:0]     nd;
      logic           nu;
      nv = req_tvalid;
      nd = req_tdata;
      nu = req_tuser;
      // an offered item stays put until its transfer
      if (!reset && !(req_tvalid && !req_took)) begin
         if (req_gap != 0) begin
            req_gap--;
            nv = 1'b0;
         end else if (pixels_to_send.size() != 0) begin
            it = pixels_to_send.pop_front();
            nv = 1'b1;
            nd = {7'b0, it.pix};
            nu = it.drain;
            req_gap = (!req_calm && $urandom_range(0, 2) == 0) ? gap_len() : 0;
         end else begin
            nv = 1'b0;
         end
         // switch between idling and back-to-back stretches now and then
         if ($urandom_range(0, 63) == 0) req_calm = !req_calm;
      end
      req_tvalid <= nv;
      req_tdata  <= nd;
      req_tuser  <= nu;
   end

   // ---------------------------------------------------------------
   // result receiver: random ready gaps plus the long hold-off
   // ---------------------------------------------------------------
   always @(negedge clock) begin : result_pacer
      logic nr;
      if (rsp_hold) begin
         nr = 1'b0;
      end else if (rdy_gap != 0) begin
         rdy_gap--;
         nr = 1'b0;
      end else begin
         nr = 1'b1;
         if (!rdy_calm && $urandom_range(0, 3) == 0) rdy_gap = gap_len();
      end
      if ($urandom_range(0, 63) == 0) rdy_calm = !rdy_calm;
      rsp_tready <= nr;
   end

   // long receiver stall, counted here so the sender keeps pushing meanwhile
   always begin : hold_timer
      @(hold_kick);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------
   task automatic push_item(input bit pix, input bit drain);
      pixel_item_type it;
      it.pix = pix;
      it.drain = drain;
      pixels_to_send.push_back(it);
      items_pushed++;
   endtask

   // all items taken, all results back, then some slack for results in flight
   task automatic wait_idle();
      while (req_xfers != items_pushed || thinned_pixels_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= DIM_W'(value);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // a whole frame plus its flush; shape picks the kind of content
   task automatic queue_frame(input int unsigned w, input int unsigned h,
                              input int unsigned shape);
      int unsigned fill, x0, x1, y0, y1;
      bit          pix;
      case (shape)
         0: fill = 15;
         1: fill = 60;
         default: fill = 85;
      endcase
      x0 = $urandom_range(0, w - 1);
      x1 = $urandom_range(x0, w - 1);
      y0 = $urandom_range(0, h - 1);
      y1 = $urandom_range(y0, h - 1);
      for (int unsigned y = 0; y < h; y++) begin
         for (int unsigned x = 0; x < w; x++) begin
            // stray drain while the frame is still coming in
            if ($urandom_range(0, 31) == 0) push_item(1'($urandom_range(0, 1)), 1'b1);
            if (shape == 3) begin
               pix = (x >= x0 && x <= x1 && y >= y0 && y <= y1) ^
                     ($urandom_range(0, 19) == 0);
            end else begin
               pix = $urandom_range(0, 99) < fill;
            end
            push_item(pix, 1'b0);
         end
      end
      // trailing flush, drain bit random since every item drains by now
      for (int unsigned i = 0; i <= w; i++) begin
         push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
   endtask

   // one item at a time until the frame in progress closes
   task automatic feed_to_frame_end();
      int unsigned ends_at_start;
      ends_at_start = frames_done;
      while (frames_done == ends_at_start) begin
         push_item(1'($urandom_range(0, 1)), 1'b0);
         while (req_xfers != items_pushed) @(negedge clock);
      end
   endtask

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   initial begin : stimulus
      bit [15:0]   blob;
      int unsigned w_raw, h_raw, w, h, sel, random_items;
      bit          first;
      blob = 16'b0110_1111_1111_0110;
      random_items = 0;
      first = 1'b1;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed: rounded 4x4 block, its corners go in the first sub-pass
      write_reg(REG_WIDTH, 4);
      write_reg(REG_HEIGHT, 4);
      write_reg(REG_SUBPASS, 0);
      for (int i = 0; i < 16; i++) begin
         if (i == 5) push_item(1'b1, 1'b1);   // early drain, must be dropped
         push_item(blob[15 - i], 1'b0);
      end
      // flush: pixel bit ignored, drain bit in both states
      push_item(1'b1, 1'b0);
      push_item(1'b0, 1'b1);
      push_item(1'b1, 1'b1);
      push_item(1'b0, 1'b0);
      push_item(1'b1, 1'b0);
      wait_idle();

      // single pixel frame: output starts on the third item
      write_reg(REG_WIDTH, 1);
      write_reg(REG_HEIGHT, 1);
      push_item(1'b1, 1'b0);
      push_item(1'b1, 1'b0);
      push_item(1'b0, 1'b1);
      wait_idle();

      // width saturates and height zero counts as one: nothing comes out while
      // the long first row streams in, then the row narrows and the frame closes
      write_reg(REG_WIDTH, 2047);
      write_reg(REG_HEIGHT, 0);
      write_reg(REG_SUBPASS, 1);
      repeat (40) push_item($urandom_range(0, 99) < 60, 1'b0);
      wait_idle();
      write_reg(REG_WIDTH, 5);
      feed_to_frame_end();
      wait_idle();

      // zero width counts as one and height saturates; the receiver holds off
      // so the block backs up into the sender, then the height drops below the
      // rows already in
      write_reg(REG_WIDTH, 0);
      write_reg(REG_HEIGHT, 2047);
      write_reg(REG_SUBPASS, 0);
      -> hold_kick;
      repeat (60) push_item($urandom_range(0, 99) < 85, 1'b0);
      wait_idle();
      write_reg(REG_HEIGHT, 3);
      feed_to_frame_end();
      wait_idle();

      // width shrinks mid-frame after two full rows; column restarts at zero
      write_reg(REG_WIDTH, 9);
      write_reg(REG_HEIGHT, 6);
      write_reg(REG_SUBPASS, 1);
      repeat (22) push_item($urandom_range(0, 99) < 70, 1'b0);
      wait_idle();
      write_reg(REG_WIDTH, 4);
      write_reg(REG_HEIGHT, 8);
      feed_to_frame_end();
      wait_idle();

      // height drops below the rows already in: frame closes at once
      write_reg(REG_WIDTH, 6);
      write_reg(REG_HEIGHT, 6);
      write_reg(REG_SUBPASS, 0);
      repeat (24) push_item($urandom_range(0, 99) < 70, 1'b0);
      wait_idle();
      write_reg(REG_HEIGHT, 2);
      feed_to_frame_end();
      wait_idle();

      // random frames, mostly small, some back to back without a register change
      while (random_items < RANDOM_ITEMS) begin
         if (first || $urandom_range(0, 1) == 1) begin
            first = 1'b0;
            wait_idle();
            sel = $urandom_range(0, 99);
            if (sel < 80) begin
               w_raw = $urandom_range(1, 10);
               h_raw = $urandom_range(1, 10);
            end else if (sel < 95) begin
               w_raw = $urandom_range(11, 48);
               h_raw = $urandom_range(1, 5);
            end else begin
               w_raw = 0;
               h_raw = $urandom_range(2, 12);
            end
            write_reg(REG_WIDTH, w_raw);
            write_reg(REG_HEIGHT, h_raw);
            write_reg(REG_SUBPASS, $urandom_range(0, 1));
            if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, $urandom_range(0, 2047));
            w = eff_dim(DIM_W'(w_raw), MAX_WIDTH);
            h = eff_dim(DIM_W'(h_raw), MAX_HEIGHT);
         end
         queue_frame(w, h, $urandom_range(0, 3));
         random_items += w * h + w + 1;
      end

      wait_idle();
      repeat (16) @(negedge clock);

      $display("covered %0d input transfers, %0d results over %0d frames, %0d pixels removed",
               req_xfers, results_checked, frames_done, pixels_removed);
      $display("%0d early drains dropped, %0d register writes incl. saturated geometry",
               drains_dropped, reg_writes);
      if (errors == 0 && thinned_pixels_due.size() == 0) begin
         $display("thinning_subpass_window_top verification clean");
      end else begin
         $display("%0d mismatches, %0d results still outstanding", errors,
                  thinned_pixels_due.size());
         $display("thinning_subpass_window_top verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
design/tsw_pkg.sv
design/tsw_line_store.sv
design/tsw_scan.sv
design/tsw_eval.sv
design/thinning_subpass_window_top.sv
design/tsw_checker.sv
tb/thinning_subpass_window_top_tb.sv
